### hw/rtl/fwia_pkg.sv
// shared types, operation codes and microcode rom for the fixed-width integer alu
// no dependencies; imported by every module of the block

package fwia_pkg;

    // word geometry
    localparam int BYTES   = 8;
    localparam int WORD_W  = BYTES * 8;
    localparam int FIELD_W = 64;
    localparam int AMT_W   = 7;
    localparam int CNT_W   = $clog2(WORD_W);
    localparam int UA_W    = 3;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_AND = 4'd5,
        OP_OR  = 4'd6,
        OP_XOR = 4'd7,
        OP_NOT = 4'd8,
        OP_SHL = 4'd9,
        OP_SHR = 4'd10,
        OP_CMP = 4'd11
    } t_op;

    // request and result payloads
    typedef struct packed {
        logic [3:0]         operation;
        logic [FIELD_W-1:0] operand_a;
        logic [FIELD_W-1:0] operand_b;
        logic [AMT_W-1:0]   shift_amount;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] result;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               result_zero;
        logic               result_odd;
    } t_rsp;

    // datapath micro-operations
    typedef enum logic [1:0] {
        DP_NOP  = 2'd0,
        DP_INIT = 2'd1,
        DP_MUL  = 2'd2,
        DP_DIV  = 2'd3
    } t_dp_op;

    // result source on the final step
    typedef enum logic [1:0] {
        RES_ALU = 2'd0,
        RES_ACC = 2'd1,
        RES_QR  = 2'd2
    } t_res_sel;

    // one control word
    typedef struct packed {
        t_dp_op          dp_op;
        t_res_sel        res_sel;
        logic            jmp_cnt;
        logic [UA_W-1:0] jmp_addr;
        logic            done;
    } t_uword;

    // sequencer to datapath control
    typedef struct packed {
        t_dp_op   dp_op;
        t_res_sel res_sel;
        logic     out_en;
    } t_ctl;

    // datapath to sequencer status
    typedef struct packed {
        logic cnt_zero;
        logic busy_op;
    } t_stat;

    // microcode addresses
    localparam logic [UA_W-1:0] UA_SINGLE = 3'd0;
    localparam logic [UA_W-1:0] UA_MUL0   = 3'd1;
    localparam logic [UA_W-1:0] UA_MUL1   = 3'd2;
    localparam logic [UA_W-1:0] UA_MUL2   = 3'd3;
    localparam logic [UA_W-1:0] UA_DIV0   = 3'd4;
    localparam logic [UA_W-1:0] UA_DIV1   = 3'd5;
    localparam logic [UA_W-1:0] UA_DIV2   = 3'd6;

    // program entry for each operation
    function automatic logic [UA_W-1:0] ucode_entry(input logic [3:0] op);
        logic [UA_W-1:0] addr;
        case (op)
            OP_MUL:  addr = UA_MUL0;
            OP_DIV:  addr = UA_DIV0;
            OP_MOD:  addr = UA_DIV0;
            default: addr = UA_SINGLE;
        endcase
        return addr;
    endfunction

    // control store
    function automatic t_uword ucode_rom(input logic [UA_W-1:0] addr);
        t_uword w;
        w.dp_op    = DP_NOP;
        w.res_sel  = RES_ALU;
        w.jmp_cnt  = 1'b0;
        w.jmp_addr = UA_SINGLE;
        w.done     = 1'b1;
        case (addr)
            UA_MUL0: begin
                w.dp_op = DP_INIT;
                w.done  = 1'b0;
            end
            UA_MUL1: begin
                w.dp_op    = DP_MUL;
                w.jmp_cnt  = 1'b1;
                w.jmp_addr = UA_MUL1;
                w.done     = 1'b0;
            end
            UA_MUL2: begin
                w.res_sel = RES_ACC;
            end
            UA_DIV0: begin
                w.dp_op = DP_INIT;
                w.done  = 1'b0;
            end
            UA_DIV1: begin
                w.dp_op    = DP_DIV;
                w.jmp_cnt  = 1'b1;
                w.jmp_addr = UA_DIV1;
                w.done     = 1'b0;
            end
            UA_DIV2: begin
                w.res_sel = RES_QR;
            end
            default: begin
                w.res_sel = RES_ALU;
            end
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/fwia_seq.sv
// microcode sequencer: step counter, control store read and conditional jumps
// depends on fwia_pkg

module fwia_seq
    import fwia_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  logic [3:0] i_op,
    input  t_stat      i_stat,
    output t_ctl       o_ctl,
    output logic       o_busy
);

    logic [UA_W-1:0] r_pc, n_pc;
    logic            r_busy, n_busy;
    t_uword          uw;

    // current control word
    assign uw = ucode_rom(r_pc);

    // control to the datapath, quiet while idle
    always_comb begin
        o_ctl.dp_op   = r_busy ? uw.dp_op : DP_NOP;
        o_ctl.res_sel = uw.res_sel;
        o_ctl.out_en  = r_busy & uw.done;
    end

    // step sequencing
    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (i_load) begin
            n_pc   = ucode_entry(i_op);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (uw.done) begin
                n_busy = 1'b0;
            end else if (uw.jmp_cnt && !i_stat.cnt_zero) begin
                n_pc = uw.jmp_addr;
            end else begin
                n_pc = r_pc + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= UA_SINGLE;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

### hw/rtl/fwia_datapath.sv
// alu datapath: operand, accumulator and bit-count registers, output register
// depends on fwia_pkg; driven by control words from fwia_seq

module fwia_datapath
    import fwia_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_req  i_req,
    input  t_ctl  i_ctl,
    output t_stat o_stat,
    output t_rsp  o_rsp,
    output logic  o_strobe
);

    logic [WORD_W-1:0] r_a, n_a;
    logic [WORD_W-1:0] r_b, n_b;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_op               r_op, n_op;
    logic [AMT_W-1:0]  r_amt, n_amt;
    logic              r_lt, n_lt, r_eq, n_eq, r_gt, n_gt;
    t_rsp              r_rsp, n_rsp;
    logic              r_strobe;

    logic [WORD_W-1:0] in_a, in_b, alu_res, res_val;
    logic [WORD_W:0]   div_sh, div_trial;

    assign in_a = i_req.operand_a[WORD_W-1:0];
    assign in_b = i_req.operand_b[WORD_W-1:0];

    // single-step operations
    always_comb begin
        case (r_op)
            OP_ADD:  alu_res = r_a + r_b;
            OP_SUB:  alu_res = r_a - r_b;
            OP_AND:  alu_res = r_a & r_b;
            OP_OR:   alu_res = r_a | r_b;
            OP_XOR:  alu_res = r_a ^ r_b;
            OP_NOT:  alu_res = ~r_a;
            OP_SHL:  alu_res = (r_amt >= AMT_W'(WORD_W)) ? '0 : (r_a << r_amt);
            OP_SHR:  alu_res = (r_amt >= AMT_W'(WORD_W)) ? '0 : (r_a >> r_amt);
            default: alu_res = '0;
        endcase
    end

    // restoring divide trial: partial remainder with next dividend bit shifted in
    assign div_sh    = {r_acc, r_a[WORD_W-1]};
    assign div_trial = div_sh - {1'b0, r_b};

    // register updates
    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_op  = r_op;
        n_amt = r_amt;
        n_lt  = r_lt;
        n_eq  = r_eq;
        n_gt  = r_gt;
        if (i_load) begin
            n_a   = in_a;
            n_b   = in_b;
            n_op  = t_op'(i_req.operation);
            n_amt = i_req.shift_amount;
            n_lt  = in_a < in_b;
            n_eq  = in_a == in_b;
            n_gt  = in_a > in_b;
        end else begin
            case (i_ctl.dp_op)
                DP_INIT: begin
                    n_acc = '0;
                    n_cnt = CNT_W'(WORD_W - 1);
                end
                DP_MUL: begin
                    if (r_b[0]) begin
                        n_acc = r_acc + r_a;
                    end
                    n_a   = r_a << 1;
                    n_b   = r_b >> 1;
                    n_cnt = r_cnt - 1'b1;
                end
                DP_DIV: begin
                    if (!div_trial[WORD_W]) begin
                        n_acc = div_trial[WORD_W-1:0];
                    end else begin
                        n_acc = div_sh[WORD_W-1:0];
                    end
                    n_a   = {r_a[WORD_W-2:0], ~div_trial[WORD_W]};
                    n_cnt = r_cnt - 1'b1;
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase
        end
    end

    // final result selection and flags
    always_comb begin
        case (i_ctl.res_sel)
            RES_ACC: res_val = r_acc;
            RES_QR:  res_val = (r_op == OP_DIV) ? r_a : r_acc;
            default: res_val = alu_res;
        endcase
        n_rsp.result      = FIELD_W'(res_val);
        n_rsp.a_less      = r_lt;
        n_rsp.a_equal     = r_eq;
        n_rsp.a_greater   = r_gt;
        n_rsp.result_zero = (res_val == '0);
        n_rsp.result_odd  = res_val[0];
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_op  <= n_op;
        r_amt <= n_amt;
        r_lt  <= n_lt;
        r_eq  <= n_eq;
        r_gt  <= n_gt;
        if (i_ctl.out_en) begin
            r_rsp <= n_rsp;
        end
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_strobe <= i_ctl.out_en;
        end
    end

    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.busy_op  = (i_ctl.dp_op != DP_NOP);
    assign o_rsp           = r_rsp;
    assign o_strobe        = r_strobe;

endmodule

### hw/rtl/fixed_width_integer_alu.sv
// top level of the fixed-width integer alu: sequencer plus datapath
// depends on fwia_pkg, fwia_seq and fwia_datapath

// A request is taken when start is high and busy is low. Add, subtract, logic,
// shift and compare-only requests run as one microcode step, which registers the
// result and strobe after the operands are registered. Multiply (shift and
// add) and divide/modulo (restoring) run an init step, iterate one bit per step
// through the shared accumulator and end in a result step; busy stays high
// until the strobe, so no new request is taken before it. o_strobe is high for
// exactly one cycle; o_rsp holds the result until the next one. The receiver
// cannot stall it, and the next request may be taken in the strobe cycle.

module fixed_width_integer_alu
    import fwia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output t_rsp o_rsp,
    output logic o_strobe
);

    logic  load;
    t_ctl  ctl;
    t_stat stat;

    // request accept
    assign load = start & ~busy;

    // microcode sequencer
    fwia_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_op    (i_req.operation),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // datapath
    fwia_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_req    (i_req),
        .i_ctl    (ctl),
        .o_stat   (stat),
        .o_rsp    (o_rsp),
        .o_strobe (o_strobe)
    );

`ifndef SYNTHESIS
    // a result strobe only follows a finished program
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while sequencer busy");

    // exactly one compare flag per result
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $onehot({o_rsp.a_less, o_rsp.a_equal, o_rsp.a_greater}))
        else $error("compare flags not one-hot");

    // result strobe timing of single-step requests
    a_single_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !(i_req.operation == OP_MUL || i_req.operation == OP_DIV ||
                   i_req.operation == OP_MOD)) |-> ##2 o_strobe)
        else $error("single-step request latency wrong");

    // iterative requests finish after one bit per step
    a_iter_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && (i_req.operation == OP_MUL || i_req.operation == OP_DIV ||
                  i_req.operation == OP_MOD)) |-> ##(WORD_W + 3) o_strobe)
        else $error("iterative request latency wrong");

    // datapath only works while a program runs
    a_dp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy_op |-> busy)
        else $error("datapath step while idle");
`endif

endmodule

### tb/sv/fwia_result_checker.sv
// result checker for the fixed-width integer alu: predicts each accepted request
// and compares every strobed result field by field; depends on fwia_pkg
`timescale 1ns / 100ps

module fwia_result_checker
    import fwia_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  t_rsp i_rsp,
    input  logic i_strobe,
    output int   o_errors,
    output int   o_pending
);

    // low WORD_W bits of a field
    localparam logic [FIELD_W-1:0] WORD_MASK = {FIELD_W{1'b1}} >> (FIELD_W - WORD_W);
    localparam int MAX_PRINTED = 40;

    typedef struct {
        t_req req;
        t_rsp rsp;
    } t_alu_expect;

    t_alu_expect expected_q[$];
    int          mismatch_count;
    int          pending_count;

    assign o_errors  = mismatch_count;
    assign o_pending = pending_count;

    // one line per mismatch, quiet after the first few dozen
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // expected response of one request
    function automatic t_rsp predict_alu_result(input t_req req);
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] r;
        t_rsp               rsp;
        a = req.operand_a & WORD_MASK;
        b = req.operand_b & WORD_MASK;
        r = '0;
        case (req.operation)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: r = (b == '0) ? WORD_MASK : a / b;
            OP_MOD: r = (b == '0) ? a : a % b;
            OP_AND: r = a & b;
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            OP_NOT: r = ~a;
            OP_SHL: r = (req.shift_amount >= WORD_W) ? '0 : a << req.shift_amount;
            OP_SHR: r = (req.shift_amount >= WORD_W) ? '0 : a >> req.shift_amount;
            OP_CMP: r = '0;
            // unused codes behave as compare only
            default: r = '0;
        endcase
        r &= WORD_MASK;
        rsp.result      = r;
        rsp.a_less      = (a < b);
        rsp.a_equal     = (a == b);
        rsp.a_greater   = (a > b);
        rsp.result_zero = (r == '0);
        rsp.result_odd  = r[0];
        return rsp;
    endfunction

    // field by field compare against the oldest request
    task automatic check_alu_response(input t_alu_expect exp, input t_rsp got);
        string tag;
        tag = $sformatf("op %0d a %h b %h amt %0d", exp.req.operation, exp.req.operand_a,
                        exp.req.operand_b, exp.req.shift_amount);
        if (got.result !== exp.rsp.result)
            report_mismatch($sformatf("%s: result %h, expected %h", tag, got.result,
                                      exp.rsp.result));
        if (got.a_less !== exp.rsp.a_less)
            report_mismatch($sformatf("%s: a_less %b, expected %b", tag, got.a_less,
                                      exp.rsp.a_less));
        if (got.a_equal !== exp.rsp.a_equal)
            report_mismatch($sformatf("%s: a_equal %b, expected %b", tag, got.a_equal,
                                      exp.rsp.a_equal));
        if (got.a_greater !== exp.rsp.a_greater)
            report_mismatch($sformatf("%s: a_greater %b, expected %b", tag, got.a_greater,
                                      exp.rsp.a_greater));
        if (got.result_zero !== exp.rsp.result_zero)
            report_mismatch($sformatf("%s: result_zero %b, expected %b", tag,
                                      got.result_zero, exp.rsp.result_zero));
        if (got.result_odd !== exp.rsp.result_odd)
            report_mismatch($sformatf("%s: result_odd %b, expected %b", tag,
                                      got.result_odd, exp.rsp.result_odd));
    endtask

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        t_alu_expect exp;
        if (!i_rst_n) begin
            expected_q.delete();
        end else begin
            // result side first: a new request may be taken in the strobe cycle
            if (i_strobe === 1'b1) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request pending",
                                              i_rsp.result));
                end else begin
                    exp = expected_q.pop_front();
                    check_alu_response(exp, i_rsp);
                end
            end
            // request side
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                exp.req = i_req;
                exp.rsp = predict_alu_result(i_req);
                expected_q.push_back(exp);
            end
        end
        pending_count = expected_q.size();
    end

endmodule

### tb/sv/tb_fixed_width_integer_alu.sv
// testbench top for the fixed-width integer alu: clock, reset, directed and random
// requests with idle gaps, verdict; depends on fwia_pkg, the alu and fwia_result_checker
`timescale 1ns / 100ps

module tb_fixed_width_integer_alu;
    import fwia_pkg::*;

    localparam logic [3:0] OP_RSVD_LO = 4'd12;
    localparam logic [3:0] OP_RSVD_HI = 4'd15;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int RANDOM_REQUESTS    = 550;
    localparam int DRAIN_CYCLES       = WORD_W + 8;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    t_rsp o_rsp;
    logic o_strobe;
    int   error_count;
    int   pending_count;
    bit   no_idle;

    fixed_width_integer_alu i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .o_strobe (o_strobe)
    );

    fwia_result_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_req     (i_req),
        .i_rsp     (o_rsp),
        .i_strobe  (o_strobe),
        .o_errors  (error_count),
        .o_pending (pending_count)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // hard stop
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (no_idle || sel < 11)
            return 0;
        else if (sel < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // operand with weight on the edges of the range
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return 64'($urandom_range(1, 16));
            3:       return 64'd1 << $urandom_range(0, 63);
            4:       return ~(64'd1 << $urandom_range(0, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // garbage on the request bus while start is low
    function automatic t_req noise_request();
        t_req req;
        req.operation    = 4'($urandom);
        req.operand_a    = {$urandom, $urandom};
        req.operand_b    = {$urandom, $urandom};
        req.shift_amount = 7'($urandom);
        return req;
    endfunction

    // present one request at a falling edge, hold until taken, then idle for a random gap, possibly none
    task automatic issue_request(input logic [3:0] op, input logic [63:0] a,
                                 input logic [63:0] b, input logic [6:0] amt);
        int gap;
        i_req <= '{operation: op, operand_a: a, operand_b: b, shift_amount: amt};
        start <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) begin
                i_req <= noise_request();
                @(negedge i_clk);
            end
        end
    endtask

    // random request: mostly valid codes, some unused ones
    task automatic issue_random_request();
        logic [3:0]  op;
        logic [63:0] a;
        logic [63:0] b;
        logic [6:0]  amt;
        if ($urandom_range(0, 99) < 94)
            op = 4'($urandom_range(OP_ADD, OP_CMP));
        else
            op = 4'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
        a = pick_operand();
        b = pick_operand();
        // equal operands and small divisors now and then
        case ($urandom_range(0, 9))
            0:       b = a;
            1:       b = 64'($urandom_range(0, 300));
            default: ;
        endcase
        amt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(64, 127))
                                          : 7'($urandom_range(0, 63));
        issue_request(op, a, b, amt);
    endtask

    // stimulus and verdict
    initial begin
        no_idle = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: edges of every operation
        issue_request(OP_ADD, ALL_ONES, 64'd1, 7'd0);
        issue_request(OP_ADD, '0, '0, 7'd127);
        issue_request(OP_SUB, '0, 64'd1, 7'd0);
        issue_request(OP_SUB, 64'h1234_5678_9ABC_DEF0, 64'h1234_5678_9ABC_DEF0, 7'd5);
        issue_request(OP_MUL, ALL_ONES, ALL_ONES, 7'd0);
        issue_request(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 7'd0);
        issue_request(OP_MUL, 64'd3, 64'h5555_5555_5555_5555, 7'd0);
        issue_request(OP_DIV, ALL_ONES, 64'd1, 7'd0);
        issue_request(OP_DIV, 64'hDEAD_BEEF_0000_0001, '0, 7'd0);
        issue_request(OP_MOD, 64'hDEAD_BEEF_0000_0001, '0, 7'd0);
        issue_request(OP_MOD, ALL_ONES, 64'h10, 7'd0);
        issue_request(OP_DIV, 64'd7, ALL_ONES, 7'd0);
        issue_request(OP_AND, 64'hF0F0_F0F0_F0F0_F0F0, 64'hFF00_FF00_FF00_FF00, 7'd0);
        issue_request(OP_OR, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 7'd0);
        issue_request(OP_XOR, ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0);
        issue_request(OP_NOT, '0, ALL_ONES, 7'd0);
        issue_request(OP_NOT, ALL_ONES, '0, 7'd0);
        issue_request(OP_SHL, 64'h8000_0000_0000_0001, '0, 7'd0);
        issue_request(OP_SHL, 64'd1, '0, 7'd63);
        issue_request(OP_SHL, ALL_ONES, '0, 7'd64);
        issue_request(OP_SHR, ALL_ONES, '0, 7'd63);
        issue_request(OP_SHR, ALL_ONES, '0, 7'd127);
        issue_request(OP_CMP, 64'd1, 64'd2, 7'd0);
        issue_request(OP_CMP, ALL_ONES, 64'd2, 7'd0);
        issue_request(OP_RSVD_LO, 64'd9, 64'd9, 7'd3);
        issue_request(OP_RSVD_HI, ALL_ONES, '0, 7'd100);

        // random: bursts without idling are mixed at random with gapped stretches
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            issue_random_request();
        end
        start <= 1'b0;

        // drain
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
